/* sv/assert_macros.svh */
// assertion macros shared by the sqrt, back and top rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PM_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pm assertion failed");

// next-cycle implication
`define PM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pm assertion failed");

`else

`define PM_ASSERT_IMPL(name, clk, rst_n, ante, cons)

`define PM_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

/* sv/pm_pkg.sv */
`timescale 1ns / 1ps

package pm_pkg;

    // field widths
    localparam int COORD_W = 16;
    localparam int H_W     = COORD_W;        // magnitude of a positive height
    localparam int B_W     = COORD_W - 1;    // magnitude of a positive base
    localparam int D_W     = COORD_W + 1;    // magnitude of the horizontal offset
    localparam int HDIFF_W = COORD_W + 1;    // signed height
    localparam int DDIFF_W = COORD_W + 2;    // signed offset
    localparam int TWOB_W  = B_W + 1;

    // squared length of the slanted side, root and remainder
    localparam int SQ_W    = 2 * D_W;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int REM_W   = ROOT_W + 1;
    localparam int SQ_NST  = ROOT_W + 1;     // sum stage plus one stage per root bit

    localparam int PERIM_W = 19;
    localparam int SURF_W  = 31;

    // sideband that rides along with the root
    typedef struct packed {
        logic [TWOB_W-1:0] twob;
        logic [SURF_W-1:0] surf;
        logic              rect;
        logic              ok;
    } t_side;

    // squares handed to the root unit
    typedef struct packed {
        logic [2*H_W-1:0] hh;
        logic [2*D_W-1:0] dd;
        t_side            side;
    } t_sq;

    // root handed to the output stage
    typedef struct packed {
        logic [ROOT_W-1:0] root;
        t_side             side;
    } t_root;

endpackage

/* sv/pm_front.sv */
`timescale 1ns / 1ps

module pm_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_hold,
    input  logic signed [pm_pkg::COORD_W-1:0] i_bottom_left_x,
    input  logic signed [pm_pkg::COORD_W-1:0] i_bottom_left_y,
    input  logic signed [pm_pkg::COORD_W-1:0] i_top_right_x,
    input  logic signed [pm_pkg::COORD_W-1:0] i_top_right_y,
    input  logic signed [pm_pkg::COORD_W-1:0] i_base_length,
    output logic                              o_valid,
    input  logic                              i_hold,
    output pm_pkg::t_sq                       o_data
);

    // stage 0 registers: magnitudes and flags
    logic                       r0_vld;
    logic [pm_pkg::H_W-1:0]     r0_ah;
    logic [pm_pkg::D_W-1:0]     r0_ad;
    logic [pm_pkg::B_W-1:0]     r0_b;
    logic                       r0_ok;
    logic                       r0_rect;

    // stage 1 registers: squares and area
    logic                       r1_vld;
    pm_pkg::t_sq                r1_data;

    logic signed [pm_pkg::HDIFF_W-1:0] n_h;
    logic signed [pm_pkg::DDIFF_W-1:0] n_d;
    logic [pm_pkg::DDIFF_W-1:0]        n_dabs;
    logic                              n_ok;
    logic                              hold0;
    logic                              hold1;
    pm_pkg::t_sq                       n1_data;

    function automatic logic signed [pm_pkg::HDIFF_W-1:0] HDIFF_W_sext(
        input logic signed [pm_pkg::COORD_W-1:0] v
    );
        return pm_pkg::HDIFF_W'(v);
    endfunction

    function automatic logic signed [pm_pkg::DDIFF_W-1:0] DDIFF_W_sext(
        input logic signed [pm_pkg::COORD_W-1:0] v
    );
        return pm_pkg::DDIFF_W'(v);
    endfunction

    // stage holds: a stage waits only when it and every stage after it is full
    assign hold1  = i_hold & r1_vld;
    assign hold0  = i_hold & r1_vld & r0_vld;
    assign o_hold = hold0;

    // height, offset and validity
    always_comb begin
        n_h    = HDIFF_W_sext(i_top_right_y) - HDIFF_W_sext(i_bottom_left_y);
        n_d    = DDIFF_W_sext(i_bottom_left_x) - DDIFF_W_sext(i_top_right_x)
               + DDIFF_W_sext(i_base_length);
        n_dabs = n_d[pm_pkg::DDIFF_W-1] ? (~n_d + 1'b1) : n_d;
        n_ok   = !n_h[pm_pkg::HDIFF_W-1] && (n_h != '0)
               && !i_base_length[pm_pkg::COORD_W-1] && (i_base_length != '0);
    end

    // stage 0: invalid shapes carry zero magnitudes so that both results come out zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (!hold0) begin
            r0_vld <= i_valid;
        end
        if (!hold0) begin
            r0_ah   <= n_ok ? n_h[pm_pkg::H_W-1:0] : '0;
            r0_ad   <= n_ok ? n_dabs[pm_pkg::D_W-1:0] : '0;
            r0_b    <= n_ok ? i_base_length[pm_pkg::B_W-1:0] : '0;
            r0_ok   <= n_ok;
            r0_rect <= (n_d == '0);
        end
    end

    // squares of height and offset, and the area
    always_comb begin
        n1_data.hh        = r0_ah * r0_ah;
        n1_data.dd        = r0_ad * r0_ad;
        n1_data.side.surf = pm_pkg::SURF_W'(r0_b) * pm_pkg::SURF_W'(r0_ah);
        n1_data.side.twob = {r0_b, 1'b0};
        n1_data.side.rect = r0_rect;
        n1_data.side.ok   = r0_ok;
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (!hold1) begin
            r1_vld <= r0_vld;
        end
        if (!hold1) begin
            r1_data <= n1_data;
        end
    end

    assign o_valid = r1_vld;
    assign o_data  = r1_data;

endmodule

/* sv/pm_sqrt.sv */
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pm_sqrt (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_hold,
    input  pm_pkg::t_sq   i_data,
    output logic          o_valid,
    input  logic          i_hold,
    output pm_pkg::t_root o_data
);

    localparam int NST = pm_pkg::SQ_NST;

    // one stage for the sum, then one stage per root bit
    logic [NST-1:0]                         r_vld;
    logic [NST-1:0][pm_pkg::SQ_W-1:0]       r_rad;
    logic [NST-1:0][pm_pkg::REM_W-1:0]      r_rem;
    logic [NST-1:0][pm_pkg::ROOT_W-1:0]     r_root;
    pm_pkg::t_side                          r_side [NST];

    logic [NST-1:0]                         n_vld;
    logic [NST-1:0][pm_pkg::SQ_W-1:0]       n_rad;
    logic [NST-1:0][pm_pkg::REM_W-1:0]      n_rem;
    logic [NST-1:0][pm_pkg::ROOT_W-1:0]     n_root;
    logic [NST-1:0]                         hold;

    logic [NST-1:0][pm_pkg::REM_W+1:0]      cur;
    logic [NST-1:0][pm_pkg::REM_W+1:0]      trial;

    // a stage waits when it and all stages after it are full and the far end waits
    always_comb begin
        for (int k = 0; k < NST; k++) begin
            hold[k] = i_hold & (&(r_vld | ~({NST{1'b1}} << k)));
        end
    end
    assign o_hold = hold[0];

    // sum of squares, then one restoring root step per stage
    always_comb begin
        n_vld[0]  = i_valid;
        n_rad[0]  = pm_pkg::SQ_W'(i_data.hh) + i_data.dd;
        n_rem[0]  = '0;
        n_root[0] = '0;
        cur[0]    = '0;
        trial[0]  = '0;
        for (int k = 1; k < NST; k++) begin
            n_vld[k] = r_vld[k-1];
            n_rad[k] = r_rad[k-1] << 2;
            cur[k]   = {r_rem[k-1], r_rad[k-1][pm_pkg::SQ_W-1 -: 2]};
            trial[k] = {1'b0, r_root[k-1], 2'b01};
            if (cur[k] >= trial[k]) begin
                n_rem[k]  = pm_pkg::REM_W'(cur[k] - trial[k]);
                n_root[k] = {r_root[k-1][pm_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = cur[k][pm_pkg::REM_W-1:0];
                n_root[k] = {r_root[k-1][pm_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (!hold[k]) begin
                r_vld[k] <= n_vld[k];
            end
            if (!hold[k]) begin
                r_rad[k]  <= n_rad[k];
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
        end
        // sideband follows its stage
        if (!hold[0]) begin
            r_side[0] <= i_data.side;
        end
        for (int k = 1; k < NST; k++) begin
            if (!hold[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid     = r_vld[NST-1];
    assign o_data.root = r_root[NST-1];
    assign o_data.side = r_side[NST-1];

    // the final remainder never exceeds twice the root
    `PM_ASSERT_IMPL(a_rem_bound, i_clk, i_rst_n, r_vld[NST-1], (r_rem[NST-1] <= {r_root[NST-1], 1'b0}))
    // a waiting last stage keeps its root
    `PM_ASSERT_NEXT(a_hold_root, i_clk, i_rst_n, hold[NST-1], $stable(r_root[NST-1]))

endmodule

/* sv/pm_back.sv */
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pm_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_hold,
    input  pm_pkg::t_root                i_data,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [pm_pkg::PERIM_W-1:0]   o_perimeter,
    output logic [pm_pkg::SURF_W-1:0]    o_surface,
    output logic                         o_is_rectangle,
    output logic                         o_shape_valid
);

    logic                          r_vld;
    logic [pm_pkg::PERIM_W-1:0]    r_perim;
    logic [pm_pkg::SURF_W-1:0]     r_surf;
    logic                          r_rect;
    logic                          r_ok;
    logic [pm_pkg::PERIM_W-1:0]    n_perim;
    logic                          hold;

    assign hold   = i_stall & r_vld;
    assign o_hold = hold;

    // twice the side plus twice the base; stays in range at these widths
    assign n_perim = pm_pkg::PERIM_W'({i_data.root, 1'b0})
                   + pm_pkg::PERIM_W'(i_data.side.twob);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!hold) begin
            r_vld <= i_valid;
        end
        if (!hold) begin
            r_perim <= n_perim;
            r_surf  <= i_data.side.surf;
            r_rect  <= i_data.side.rect;
            r_ok    <= i_data.side.ok;
        end
    end

    assign o_valid        = r_vld;
    assign o_perimeter    = r_perim;
    assign o_surface      = r_surf;
    assign o_is_rectangle = r_rect;
    assign o_shape_valid  = r_ok;

    // an invalid shape gives zero perimeter and zero area
    `PM_ASSERT_IMPL(a_invalid_zero, i_clk, i_rst_n, r_vld && !r_ok, (r_perim == '0) && (r_surf == '0))

endmodule

/* sv/parallelogram_measure.sv */
`timescale 1ns / 1ps
// an accepted item passes the front stages, then the root stages, then the output register
// throughput: one item per cycle while no stall holds it; the integer square root is an 18 stage pipeline
// (a sum stage, then one root bit per stage), fed by two stages of differences and squares
// a stall holds only the full stages behind it, empty stages keep filling
// reset (synchronous, active low) clears every stage valid bit; data needs no reset

`include "assert_macros.svh"

module parallelogram_measure (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [pm_pkg::COORD_W-1:0] i_bottom_left_x,
    input  logic signed [pm_pkg::COORD_W-1:0] i_bottom_left_y,
    input  logic signed [pm_pkg::COORD_W-1:0] i_top_right_x,
    input  logic signed [pm_pkg::COORD_W-1:0] i_top_right_y,
    input  logic signed [pm_pkg::COORD_W-1:0] i_base_length,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [pm_pkg::PERIM_W-1:0]        o_perimeter,
    output logic [pm_pkg::SURF_W-1:0]         o_surface,
    output logic                              o_is_rectangle,
    output logic                              o_shape_valid
);

    logic          sq_valid;
    logic          sq_hold;
    pm_pkg::t_sq   sq_data;
    logic          rt_valid;
    logic          rt_hold;
    pm_pkg::t_root rt_data;

    // differences, squares and area
    pm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_hold          (o_stall),
        .i_bottom_left_x (i_bottom_left_x),
        .i_bottom_left_y (i_bottom_left_y),
        .i_top_right_x   (i_top_right_x),
        .i_top_right_y   (i_top_right_y),
        .i_base_length   (i_base_length),
        .o_valid         (sq_valid),
        .i_hold          (sq_hold),
        .o_data          (sq_data)
    );

    // slanted side
    pm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .o_hold  (sq_hold),
        .i_data  (sq_data),
        .o_valid (rt_valid),
        .i_hold  (rt_hold),
        .o_data  (rt_data)
    );

    // perimeter and output register
    pm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (rt_valid),
        .o_hold         (rt_hold),
        .i_data         (rt_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_perimeter    (o_perimeter),
        .o_surface      (o_surface),
        .o_is_rectangle (o_is_rectangle),
        .o_shape_valid  (o_shape_valid)
    );

    // the input waits only behind a full pipeline with a waiting result
    `PM_ASSERT_IMPL(a_stall_needs_result, i_clk, i_rst_n, o_stall, o_valid && i_stall)

endmodule

/* verif/parallelogram_measure_tb.sv */
`timescale 1ns / 1ps

module parallelogram_measure_tb;

    localparam int  CYCLE_LIMIT = 200000;
    localparam int  RANDOM_SHAPES = 800;
    localparam int  SETTLE_CYCLES = 40;
    localparam longint unsigned PERIM_SAT = (64'd1 << pm_pkg::PERIM_W) - 1;
    localparam longint unsigned SURF_SAT  = (64'd1 << pm_pkg::SURF_W) - 1;
    localparam longint          SIDE_LIMIT = 64'd1048576;

    // kinds of random shape
    typedef enum int {
        SHAPE_SLANTED,
        SHAPE_RECTANGLE,
        SHAPE_FLAT,
        SHAPE_NOISE
    } t_shape_kind;

    typedef struct {
        logic [pm_pkg::PERIM_W-1:0] perimeter;
        logic [pm_pkg::SURF_W-1:0]  surface;
        logic                       is_rectangle;
        logic                       shape_valid;
    } t_measure;

    // expected measures of accepted shapes, oldest first
    class measure_board;
        t_measure pending_measures[$];
        int       mismatches;

        function new();
            mismatches = 0;
        endfunction

        // floor of the square root, one result bit at a time from the top
        function longint unsigned root_floor(longint unsigned n);
            longint unsigned r;
            longint unsigned trial;
            r = 0;
            for (int i = 31; i >= 0; i--) begin
                trial = r | (64'd1 << i);
                if (trial * trial <= n)
                    r = trial;
            end
            return r;
        endfunction

        function t_measure predict_measure(logic signed [pm_pkg::COORD_W-1:0] bx,
                                           logic signed [pm_pkg::COORD_W-1:0] by,
                                           logic signed [pm_pkg::COORD_W-1:0] tx,
                                           logic signed [pm_pkg::COORD_W-1:0] ty,
                                           logic signed [pm_pkg::COORD_W-1:0] b);
            t_measure        m;
            longint          h;
            longint          d;
            longint          base;
            longint unsigned ah;
            longint unsigned ad;
            longint unsigned side;
            longint unsigned perim;
            longint unsigned surf;
            base = longint'(b);
            h    = longint'(ty) - longint'(by);
            d    = longint'(bx) - (longint'(tx) - base);
            ah   = (h < 0) ? -h : h;
            ad   = (d < 0) ? -d : d;
            perim = 0;
            surf  = 0;
            m.shape_valid  = (h > 0) && (base > 0);
            m.is_rectangle = (d == 0);
            if (m.shape_valid) begin
                if (ah >= SIDE_LIMIT || ad >= SIDE_LIMIT) begin
                    perim = PERIM_SAT;
                end else begin
                    side  = root_floor(ah * ah + ad * ad);
                    perim = 2 * side + 2 * longint'(base);
                    if (perim > PERIM_SAT)
                        perim = PERIM_SAT;
                end
                surf = longint'(base) * ah;
                if (surf > SURF_SAT)
                    surf = SURF_SAT;
            end
            m.perimeter = perim[pm_pkg::PERIM_W-1:0];
            m.surface   = surf[pm_pkg::SURF_W-1:0];
            return m;
        endfunction

        function void note_shape(logic signed [pm_pkg::COORD_W-1:0] bx,
                                 logic signed [pm_pkg::COORD_W-1:0] by,
                                 logic signed [pm_pkg::COORD_W-1:0] tx,
                                 logic signed [pm_pkg::COORD_W-1:0] ty,
                                 logic signed [pm_pkg::COORD_W-1:0] b);
            pending_measures.push_back(predict_measure(bx, by, tx, ty, b));
        endfunction

        function void check_measure(logic [pm_pkg::PERIM_W-1:0] perimeter,
                                    logic [pm_pkg::SURF_W-1:0]  surface,
                                    logic                       is_rectangle,
                                    logic                       shape_valid);
            t_measure m;
            if (pending_measures.size() == 0) begin
                $error("result with no shape outstanding");
                mismatches++;
                return;
            end
            m = pending_measures.pop_front();
            if (perimeter !== m.perimeter) begin
                $error("perimeter: expected %0d, got %0d", m.perimeter, perimeter);
                mismatches++;
            end
            if (surface !== m.surface) begin
                $error("surface: expected %0d, got %0d", m.surface, surface);
                mismatches++;
            end
            if (is_rectangle !== m.is_rectangle) begin
                $error("is_rectangle: expected %0b, got %0b", m.is_rectangle, is_rectangle);
                mismatches++;
            end
            if (shape_valid !== m.shape_valid) begin
                $error("shape_valid: expected %0b, got %0b", m.shape_valid, shape_valid);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_measures.size();
        endfunction
    endclass

    logic                               i_clk;
    logic                               i_rst_n = 1'b0;
    logic                               i_valid = 1'b0;
    logic                               o_stall;
    logic signed [pm_pkg::COORD_W-1:0]  i_bottom_left_x = '0;
    logic signed [pm_pkg::COORD_W-1:0]  i_bottom_left_y = '0;
    logic signed [pm_pkg::COORD_W-1:0]  i_top_right_x = '0;
    logic signed [pm_pkg::COORD_W-1:0]  i_top_right_y = '0;
    logic signed [pm_pkg::COORD_W-1:0]  i_base_length = '0;
    logic                               o_valid;
    logic                               i_stall = 1'b0;
    logic [pm_pkg::PERIM_W-1:0]         o_perimeter;
    logic [pm_pkg::SURF_W-1:0]          o_surface;
    logic                               o_is_rectangle;
    logic                               o_shape_valid;

    measure_board board;
    logic         no_idle = 1'b0;
    int           cycle_count = 0;

    parallelogram_measure dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_bottom_left_x (i_bottom_left_x),
        .i_bottom_left_y (i_bottom_left_y),
        .i_top_right_x   (i_top_right_x),
        .i_top_right_y   (i_top_right_y),
        .i_base_length   (i_base_length),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_perimeter     (o_perimeter),
        .o_surface       (o_surface),
        .o_is_rectangle  (o_is_rectangle),
        .o_shape_valid   (o_shape_valid)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // cycle budget
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: random stall, check every item taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_measure(o_perimeter, o_surface, o_is_rectangle, o_shape_valid);
        if (!i_rst_n || no_idle)
            i_stall <= 1'b0;
        else
            i_stall <= ($urandom_range(0, 99) < 10);
    end

    // offer one shape, with random idle cycles ahead of it, until taken
    task automatic send_shape(input logic signed [pm_pkg::COORD_W-1:0] bx,
                              input logic signed [pm_pkg::COORD_W-1:0] by,
                              input logic signed [pm_pkg::COORD_W-1:0] tx,
                              input logic signed [pm_pkg::COORD_W-1:0] ty,
                              input logic signed [pm_pkg::COORD_W-1:0] b);
        while (!no_idle && $urandom_range(0, 99) < 10) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_bottom_left_x <= bx;
        i_bottom_left_y <= by;
        i_top_right_x   <= tx;
        i_top_right_y   <= ty;
        i_base_length   <= b;
        do
            @(posedge i_clk);
        while (o_stall);
        board.note_shape(i_bottom_left_x, i_bottom_left_y, i_top_right_x,
                         i_top_right_y, i_base_length);
    endtask

    // hold off until every outstanding shape has come back
    task automatic drain_measures();
        i_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_random_shape(input t_shape_kind kind);
        int bxi;
        int byi;
        int txi;
        int tyi;
        int bi;
        bxi = int'($urandom_range(0, 65535)) - 32768;
        txi = int'($urandom_range(0, 65535)) - 32768;
        byi = int'($urandom_range(0, 65534)) - 32768;
        tyi = byi + 1 + int'($urandom_range(0, 32766 - byi));
        bi  = int'($urandom_range(1, 32767));
        // a third of the time keep the sizes small
        if ($urandom_range(0, 2) == 0) begin
            bi  = int'($urandom_range(1, 256));
            tyi = byi + 1 + int'($urandom_range(0, (32766 - byi < 255) ? 32766 - byi : 255));
        end
        case (kind)
            SHAPE_RECTANGLE: begin
                bxi = int'($urandom_range(0, 65535 - bi)) - 32768;
                txi = bxi + bi;
            end
            SHAPE_FLAT: begin
                // degenerate height or base: zero or negative
                case ($urandom_range(0, 3))
                    0: tyi = byi;
                    1: bi = 0;
                    2: bi = -int'($urandom_range(1, 32768));
                    default: begin
                        tyi = int'($urandom_range(0, 65535)) - 32768;
                        byi = tyi + int'($urandom_range(0, 32767 - tyi));
                    end
                endcase
            end
            SHAPE_NOISE: begin
                byi = int'($urandom_range(0, 65535)) - 32768;
                tyi = int'($urandom_range(0, 65535)) - 32768;
                bi  = int'($urandom_range(0, 65535)) - 32768;
            end
            default: ;
        endcase
        send_shape(bxi[pm_pkg::COORD_W-1:0], byi[pm_pkg::COORD_W-1:0],
                   txi[pm_pkg::COORD_W-1:0], tyi[pm_pkg::COORD_W-1:0],
                   bi[pm_pkg::COORD_W-1:0]);
    endtask

    initial begin : stimulus
        t_shape_kind kind;
        int          pick;
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes of every field
        send_shape(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_shape(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_shape(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_shape(-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
        // largest surface: full height and full base
        send_shape(16'sd0, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767);
        // largest perimeter: widest offset at full height
        send_shape(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
        // widest offset leaning the other way
        send_shape(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd1);
        // smallest valid shape
        send_shape(16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd1);
        // rectangles, valid and not, around a full-size slanted shape
        send_shape(16'sd160, 16'sd16, 16'sd480, 16'sd96, 16'sd320);
        send_shape(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767);
        send_shape(16'sd0, 16'sd16, 16'sd32, 16'sd16, 16'sd32);
        // exact root: offset 64, height 48
        send_shape(16'sd64, 16'sd0, 16'sd160, 16'sd48, 16'sd160);
        // root rounded down: offset 1, height 1
        send_shape(16'sd1, 16'sd0, 16'sd16, 16'sd1, 16'sd16);
        // zero height, negative height
        send_shape(16'sd10, 16'sd100, 16'sd50, 16'sd100, 16'sd40);
        send_shape(16'sd10, 16'sd100, 16'sd50, 16'sd99, 16'sd40);
        // zero base, negative base
        send_shape(16'sd10, 16'sd0, 16'sd50, 16'sd100, 16'sd0);
        send_shape(16'sd10, 16'sd0, 16'sd50, 16'sd100, -16'sd40);
        // height just overflowing the input range on the downward side
        send_shape(16'sd0, 16'sd32767, 16'sd16, -16'sd32768, 16'sd16);
        drain_measures();

        for (int n = 0; n < RANDOM_SHAPES; n++) begin
            no_idle <= (n >= 100 && n < 300);
            if (n == 400)
                drain_measures();
            pick = $urandom_range(0, 99);
            if (pick < 60)
                kind = SHAPE_SLANTED;
            else if (pick < 75)
                kind = SHAPE_RECTANGLE;
            else if (pick < 85)
                kind = SHAPE_FLAT;
            else
                kind = SHAPE_NOISE;
            send_random_shape(kind);
        end
        no_idle <= 1'b0;
        drain_measures();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
